[hw/rtl/gsrs_pkg.sv]
package gsrs_pkg;

    // Reply table codes
    typedef enum logic [3:0] {
        TBL_POLL    = 4'd0,
        TBL_TOG_OUT = 4'd1,
        TBL_QUERY   = 4'd2,
        TBL_TOG_IN  = 4'd3,
        TBL_SETMODE = 4'd4,
        TBL_STATUS  = 4'd5,
        TBL_C46_0   = 4'd6,
        TBL_C46_1   = 4'd7,
        TBL_C47     = 4'd8,
        TBL_C4C_0   = 4'd9,
        TBL_C4C_1   = 4'd10
    } t_table;

    localparam int TABLE_COUNT = 11;
    localparam int TABLE_BYTES = 8;
    localparam int PAD_BYTES   = 6;

    // Command codes seen at frame position 1
    localparam logic [7:0] CMD_QUERY   = 8'h41;
    localparam logic [7:0] CMD_POLL    = 8'h42;
    localparam logic [7:0] CMD_TOGGLE  = 8'h43;
    localparam logic [7:0] CMD_SETMODE = 8'h44;
    localparam logic [7:0] CMD_STATUS  = 8'h45;
    localparam logic [7:0] CMD_C46     = 8'h46;
    localparam logic [7:0] CMD_C47     = 8'h47;
    localparam logic [7:0] CMD_C4C     = 8'h4C;
    localparam logic [7:0] CMD_NONE    = 8'hFF;

    localparam logic [7:0] BYTE_IDLE   = 8'hFF;

    typedef logic [7:0] t_byte;

    // Fixed reply bytes, one row per table code
    localparam t_byte REPLY_ROM [TABLE_COUNT][TABLE_BYTES] = '{
        '{8'h73, 8'h5A, 8'hFF, 8'hFF, 8'h7F, 8'h7F, 8'h7F, 8'h7F},
        '{8'h73, 8'h5A, 8'hFF, 8'hFF, 8'h7F, 8'h7F, 8'h7F, 8'h7F},
        '{8'hF3, 8'h5A, 8'hFF, 8'hFF, 8'h03, 8'h00, 8'h00, 8'h5A},
        '{8'hF3, 8'h5A, 8'hFF, 8'hFF, 8'h7F, 8'h7F, 8'h7F, 8'h7F},
        '{8'hF3, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hF3, 8'h5A, 8'h03, 8'h02, 8'h01, 8'h02, 8'h01, 8'h00},
        '{8'hF3, 8'h5A, 8'h00, 8'h00, 8'h01, 8'h02, 8'h00, 8'h0A},
        '{8'hF3, 8'h5A, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h14},
        '{8'hF3, 8'h5A, 8'h00, 8'h00, 8'h02, 8'h00, 8'h01, 8'h00},
        '{8'hF3, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h04, 8'h00, 8'h00},
        '{8'hF3, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h07, 8'h00, 8'h00}
    };

    // Pad bytes after reset: two key bytes released, sticks centred
    localparam t_byte PAD_RESET [PAD_BYTES] = '{
        8'hFF, 8'hFF, 8'h7F, 8'h7F, 8'h7F, 8'h7F
    };

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic [13:0] buttons;
        logic [7:0] left_x;
        logic [7:0] left_y;
        logic [7:0] right_x;
        logic [7:0] right_y;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       ack;
        logic       in_config;
    } t_result;

    // Handshake between the input stage and the result stage
    typedef struct packed {
        logic take;
        logic space;
    } t_stage_ctl;

    function automatic t_byte fixed_byte(input t_table tbl, input logic [2:0] pos);
        t_byte b;
        if (int'(tbl) < TABLE_COUNT) begin
            b = REPLY_ROM[int'(tbl)][pos];
        end else begin
            b = REPLY_ROM[int'(TBL_POLL)][pos];
        end
        return b;
    endfunction

    function automatic logic uses_pad(input t_table tbl);
        return (tbl == TBL_POLL) || (tbl == TBL_TOG_OUT) || (tbl == TBL_TOG_IN);
    endfunction

    function automatic t_table pick_table(input logic [7:0] cmd, input logic cfg);
        t_table t;
        t = TBL_POLL;
        if (cfg) begin
            unique case (cmd)
                CMD_QUERY:   t = TBL_QUERY;
                CMD_TOGGLE:  t = TBL_TOG_IN;
                CMD_SETMODE: t = TBL_SETMODE;
                CMD_STATUS:  t = TBL_STATUS;
                CMD_C46:     t = TBL_C46_0;
                CMD_C47:     t = TBL_C47;
                CMD_C4C:     t = TBL_C4C_0;
                default:     t = TBL_POLL;
            endcase
        end else if (cmd == CMD_TOGGLE) begin
            t = TBL_TOG_OUT;
        end
        return t;
    endfunction

endpackage

[hw/rtl/gsrs_in_if.sv]
interface gsrs_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [7:0]  rx_byte;
    logic [13:0] buttons;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;

    modport source (
        output valid, mode, rx_byte, buttons, left_x, left_y, right_x, right_y,
        input  ready
    );
    modport sink (
        input  valid, mode, rx_byte, buttons, left_x, left_y, right_x, right_y,
        output ready
    );
endinterface

[hw/rtl/gsrs_out_if.sv]
interface gsrs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       ack;
    logic       in_config;

    modport source (
        output valid, tx_byte, ack, in_config,
        input  ready
    );
    modport sink (
        input  valid, tx_byte, ack, in_config,
        output ready
    );
endinterface

[hw/rtl/gsrs_in_stage.sv]
module gsrs_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gsrs_in_if.sink              i_in,
    input  logic                 i_space,
    output logic                 o_valid,
    output gsrs_pkg::t_in_item   o_item
);

    logic               r_valid;
    gsrs_pkg::t_in_item r_item;
    logic               take;

    // Hand the held transaction on whenever the result stage has room
    assign take       = r_valid && i_space;
    assign i_in.ready = !r_valid || take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    // Hold the accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_item <= '{mode:    i_in.mode,
                        rx_byte: i_in.rx_byte,
                        buttons: i_in.buttons,
                        left_x:  i_in.left_x,
                        left_y:  i_in.left_y,
                        right_x: i_in.right_x,
                        right_y: i_in.right_y};
        end
    end

endmodule

[hw/rtl/gsrs_core.sv]
module gsrs_core #(
    parameter int FRAME_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gsrs_pkg::t_stage_ctl i_ctl,
    input  gsrs_pkg::t_in_item   i_item,
    output logic                 o_has_result,
    output gsrs_pkg::t_result    o_result
);

    // Frame end position; every position below it answers with acknowledge
    localparam int         LIMIT   = (FRAME_BYTES < 15) ? FRAME_BYTES : 15;
    localparam logic [3:0] IDX_END = 4'(LIMIT);

    logic [3:0]        r_byte_index, n_byte_index;
    logic [7:0]        r_command, n_command;
    logic              r_config_flag, n_config_flag;
    gsrs_pkg::t_table  r_reply_table, n_reply_table;
    gsrs_pkg::t_byte   r_pad [gsrs_pkg::PAD_BYTES];
    gsrs_pkg::t_byte   n_pad [gsrs_pkg::PAD_BYTES];

    logic [7:0] tx_byte;
    logic       ack;
    logic [2:0] pad_sel;

    // Pick the reply byte at the current position
    always_comb begin
        pad_sel = r_byte_index[2:0] - 3'd2;
        if (r_byte_index[3]) begin
            tx_byte = gsrs_pkg::BYTE_IDLE;
        end else if (gsrs_pkg::uses_pad(r_reply_table) && (r_byte_index[2:1] != 2'b00)) begin
            tx_byte = r_pad[pad_sel];
        end else begin
            tx_byte = gsrs_pkg::fixed_byte(r_reply_table, r_byte_index[2:0]);
        end
    end

    // Advance the frame sequencer or refresh the pad bytes
    always_comb begin
        n_byte_index  = r_byte_index;
        n_command     = r_command;
        n_config_flag = r_config_flag;
        n_reply_table = r_reply_table;
        n_pad         = r_pad;
        ack           = 1'b0;
        o_result.tx_byte = tx_byte;
        if (i_item.mode) begin
            n_pad[0] = ~{i_item.buttons[5:2], i_item.buttons[1], 2'b00, i_item.buttons[0]};
            n_pad[1] = ~i_item.buttons[13:6];
            n_pad[2] = i_item.right_x;
            n_pad[3] = i_item.right_y;
            n_pad[4] = i_item.left_x;
            n_pad[5] = i_item.left_y;
        end else if (r_byte_index == 4'd1) begin
            n_command     = i_item.rx_byte;
            n_reply_table = gsrs_pkg::pick_table(i_item.rx_byte, r_config_flag);
            ack           = 1'b1;
            n_byte_index  = 4'd2;
        end else begin
            if (r_byte_index == 4'd3) begin
                if (r_command == gsrs_pkg::CMD_TOGGLE) begin
                    n_config_flag = i_item.rx_byte[0];
                end else if (r_command == gsrs_pkg::CMD_C46) begin
                    n_reply_table = i_item.rx_byte[0] ? gsrs_pkg::TBL_C46_1
                                                      : gsrs_pkg::TBL_C46_0;
                end else if (r_command == gsrs_pkg::CMD_C4C) begin
                    n_reply_table = i_item.rx_byte[0] ? gsrs_pkg::TBL_C4C_1
                                                      : gsrs_pkg::TBL_C4C_0;
                end
            end
            if (r_byte_index < IDX_END) begin
                ack          = 1'b1;
                n_byte_index = r_byte_index + 4'd1;
            end else begin
                // Frame end: send idle and restart the position
                n_byte_index     = 4'd0;
                o_result.tx_byte = gsrs_pkg::BYTE_IDLE;
            end
        end
        o_result.ack       = ack;
        o_result.in_config = n_config_flag;
    end

    assign o_has_result = !i_item.mode;

    // Hold sequencer state and pad bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index  <= 4'd0;
            r_command     <= gsrs_pkg::CMD_NONE;
            r_config_flag <= 1'b0;
            r_reply_table <= gsrs_pkg::TBL_POLL;
            r_pad         <= gsrs_pkg::PAD_RESET;
        end else if (i_ctl.take) begin
            r_byte_index  <= n_byte_index;
            r_command     <= n_command;
            r_config_flag <= n_config_flag;
            r_reply_table <= n_reply_table;
            r_pad         <= n_pad;
        end
    end

    // Position never runs past the frame end
    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index <= IDX_END)
        else $error("byte index past frame end");

    // A byte without acknowledge is always the idle byte
    a_nack_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.take && o_has_result && !o_result.ack) |->
        (o_result.tx_byte == gsrs_pkg::BYTE_IDLE) && (n_byte_index == 4'd0))
        else $error("unacknowledged byte is not idle");

    // Config mode moves only on the data byte of a toggle command
    a_cfg_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.take && !i_item.mode && (r_byte_index == 4'd3) &&
          (r_command == gsrs_pkg::CMD_TOGGLE)) |=> $stable(r_config_flag))
        else $error("config flag changed outside toggle data byte");

endmodule

[hw/rtl/gsrs_out_stage.sv]
module gsrs_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  gsrs_pkg::t_result i_result,
    output logic              o_space,
    gsrs_out_if.source        o_out
);

    logic              r_valid;
    gsrs_pkg::t_result r_result;

    // Room when empty or when the held transaction leaves this cycle
    assign o_space = !r_valid || o_out.ready;

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
        if (o_space && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.tx_byte   = r_result.tx_byte;
    assign o_out.ack       = r_result.ack;
    assign o_out.in_config = r_result.in_config;

endmodule

[hw/rtl/gamepad_spi_reply_sequencer_top.sv]
// Game-pad reply sequencer: slave side of the pad byte exchange.
// Input channel i_in (valid/ready) carries either a received SPI byte
// (mode 0, rx_byte) or a pad state update (mode 1: buttons and sticks).
// Output channel o_out (valid/ready) carries one transaction per received
// byte: tx_byte to load for the next transfer, ack to pulse, and in_config.
// Pad updates give no output transaction; they refresh the key and stick
// bytes served at positions 2 to 7 of the poll and toggle replies.
// Path: an accepted input transaction is held in the input register, and its
// result is then held in the result register.
// Throughput: one transaction per cycle while o_out.ready stays high; the
// whole step for one item is one pass of logic between the input register
// and the result register. When the receiver holds o_out.ready low, the
// result register holds its transaction, the input register fills behind
// it, and then i_in.ready drops; nothing is lost or repeated.
// Reset (synchronous, active low): both registers empty, frame position 0,
// command none, config mode off, poll table selected, keys released and
// sticks centred. FRAME_BYTES, capped at 15, sets the frame end, where idle
// is sent without acknowledge and the position restarts.
module gamepad_spi_reply_sequencer_top #(
    parameter int FRAME_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gsrs_in_if.sink     i_in,
    gsrs_out_if.source  o_out
);

    gsrs_pkg::t_stage_ctl ctl;
    gsrs_pkg::t_in_item   item;
    gsrs_pkg::t_result    result;
    logic                 item_valid;
    logic                 has_result;
    logic                 space;

    assign ctl = '{take: item_valid && space, space: space};

    gsrs_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_space (space),
        .o_valid (item_valid),
        .o_item  (item)
    );

    gsrs_core #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_item       (item),
        .o_has_result (has_result),
        .o_result     (result)
    );

    gsrs_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (ctl.take && has_result),
        .i_result (result),
        .o_space  (space),
        .o_out    (o_out)
    );

endmodule
